FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, off while rst_ni is low.
`define OKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication.
`define OKST_ASSERT_NEXT(lbl, pre, post, msg) \
  `OKST_ASSERT(lbl, (pre) |=> (post), msg)

`endif

FILE: src/okst_pkg.sv
`default_nettype none

package okst_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_FIND   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_POS  = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    FP_ZERO  = 3'd0,
    FP_IDX   = 3'd1,
    FP_HIT   = 3'd2,
    FP_COUNT = 3'd3,
    FP_POS   = 3'd4
  } fpos_sel_e;

  typedef struct packed {
    logic      capture;
    logic      idx_inc;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    logic      wr_append;
    logic      count_inc;
    logic      count_dec;
    logic      save_hit;
    logic      finish;
    status_e   status;
    fpos_sel_e fpos_sel;
    logic      load_entry;
  } okst_cmd_t;

  typedef struct packed {
    action_e action;
    logic    idx_lt_count;
    logic    next_lt_count;
    logic    read_ok;
    logic    full;
    logic    hit;
  } okst_stat_t;

endpackage

`default_nettype wire

FILE: src/okst_ram.sv
`default_nettype none

module okst_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: src/okst_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module okst_ctrl import okst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire okst_stat_t stat_i,
  output okst_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_LOOK      = 8'b0000_0010,
    S_CMP       = 8'b0000_0100,
    S_APPEND    = 8'b0000_1000,
    S_MOVE_RD   = 8'b0001_0000,
    S_MOVE_WR   = 8'b0010_0000,
    S_READ      = 8'b0100_0000,
    S_READ_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat_i.action == ACT_READ) begin
          state_d = S_READ;
        end else if (stat_i.idx_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d = S_CMP;
        end else if (stat_i.action == ACT_ADD) begin
          if (stat_i.full) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_FULL;
            state_d = S_IDLE;
          end else begin
            state_d = S_APPEND;
          end
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_MISSING;
          state_d = S_IDLE;
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          if (stat_i.action == ACT_REMOVE) begin
            cmd_o.save_hit = 1'b1;
            state_d = S_MOVE_RD;
          end else begin
            cmd_o.finish   = 1'b1;
            cmd_o.status   = (stat_i.action == ACT_ADD) ? ST_DUP : ST_OK;
            cmd_o.fpos_sel = FP_IDX;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_APPEND: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_append = 1'b1;
        cmd_o.count_inc = 1'b1;
        cmd_o.finish    = 1'b1;
        cmd_o.status    = ST_OK;
        cmd_o.fpos_sel  = FP_COUNT;
        state_d = S_IDLE;
      end
      S_MOVE_RD: begin
        if (stat_i.next_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d = S_MOVE_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          cmd_o.finish    = 1'b1;
          cmd_o.status    = ST_OK;
          cmd_o.fpos_sel  = FP_HIT;
          state_d = S_IDLE;
        end
      end
      S_MOVE_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = S_MOVE_RD;
      end
      S_READ: begin
        if (stat_i.read_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_POS;
          state_d = S_READ_DONE;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_MISSING;
          state_d = S_IDLE;
        end
      end
      S_READ_DONE: begin
        cmd_o.finish     = 1'b1;
        cmd_o.status     = ST_OK;
        cmd_o.fpos_sel   = FP_POS;
        cmd_o.load_entry = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  `OKST_ASSERT_NEXT(a_start_leaves_idle, start && state_q == S_IDLE, state_q != S_IDLE,
                    "accepted transaction did not leave idle")
  `OKST_ASSERT(a_finish_to_idle, cmd_o.finish |-> state_d == S_IDLE,
               "finish without return to idle")

endmodule

`default_nettype wire

FILE: src/okst_dp.sv
`default_nettype none
`include "assert_macros.svh"

module okst_dp import okst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic        [1:0]  action_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] entry_data_i,
  input  wire logic               has_data_i,
  input  wire logic        [3:0]  position_i,
  input  wire okst_cmd_t          cmd_i,
  output okst_stat_t              stat_o,
  output logic                    done_o,
  output logic             [1:0]  status_o,
  output logic             [3:0]  found_position_o,
  output logic signed      [31:0] key_out_o,
  output logic signed      [31:0] data_out_o,
  output logic             [4:0]  count_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 4) ? CW : 4;
  localparam int WW = (CW > 5) ? CW : 5;

  action_e        action_q;
  logic [31:0]    key_q;
  logic [31:0]    data_q;
  logic [3:0]     pos_q;
  logic [CW-1:0]  idx_q;
  logic [CW-1:0]  count_q;
  logic [IW-1:0]  hit_pos_q;
  logic           done_q;
  status_e        res_status_q;
  logic [3:0]     res_fpos_q;
  logic [31:0]    res_key_q;
  logic [31:0]    res_data_q;

  logic [CW-1:0]  next_idx;
  logic [EW-1:0]  pos_ext;
  logic [IW-1:0]  pos_addr;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wr_addr;
  logic [63:0]    wr_data;
  logic [63:0]    rd_data;
  logic [IW-1:0]  fpos_val;
  logic [WW-1:0]  fpos_wide;
  logic [WW-1:0]  count_wide;

  assign next_idx = idx_q + CW'(1);
  assign pos_ext  = EW'(pos_q);
  assign pos_addr = pos_ext[IW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:  rd_addr = idx_q[IW-1:0];
      RD_NEXT: rd_addr = next_idx[IW-1:0];
      RD_POS:  rd_addr = pos_addr;
      default: rd_addr = idx_q[IW-1:0];
    endcase
  end

  assign wr_addr = cmd_i.wr_append ? count_q[IW-1:0] : idx_q[IW-1:0];
  assign wr_data = cmd_i.wr_append ? {key_q, data_q} : rd_data;

  okst_ram #(
    .Width (64),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign stat_o.action        = action_q;
  assign stat_o.idx_lt_count  = (idx_q < count_q);
  assign stat_o.next_lt_count = (next_idx < count_q);
  assign stat_o.read_ok       = (pos_ext < EW'(count_q)) && (int'(pos_q) < CAPACITY);
  assign stat_o.full          = (count_q == CW'(CAPACITY));
  assign stat_o.hit           = (rd_data[63:32] == key_q);

  always_comb begin
    case (cmd_i.fpos_sel)
      FP_ZERO:  fpos_val = '0;
      FP_IDX:   fpos_val = idx_q[IW-1:0];
      FP_HIT:   fpos_val = hit_pos_q;
      FP_COUNT: fpos_val = count_q[IW-1:0];
      FP_POS:   fpos_val = pos_addr;
      default:  fpos_val = '0;
    endcase
  end

  assign fpos_wide = WW'(fpos_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= ACT_ADD;
      idx_q    <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.capture) begin
        action_q <= action_e'(action_i);
        idx_q    <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= next_idx;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= key_i;
      data_q <= has_data_i ? entry_data_i : 32'd0;
      pos_q  <= position_i;
    end
    if (cmd_i.save_hit) begin
      hit_pos_q <= idx_q[IW-1:0];
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.status;
      res_fpos_q   <= fpos_wide[3:0];
      res_key_q    <= cmd_i.load_entry ? rd_data[63:32] : 32'd0;
      res_data_q   <= cmd_i.load_entry ? rd_data[31:0] : 32'd0;
    end
  end

  assign count_wide       = WW'(count_q);
  assign done_o           = done_q;
  assign status_o         = res_status_q;
  assign found_position_o = res_fpos_q;
  assign key_out_o        = res_key_q;
  assign data_out_o       = res_data_q;
  assign count_o          = count_wide[4:0];

  `OKST_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `OKST_ASSERT(a_count_on_finish, count_q != $past(count_q) |-> $past(cmd_i.finish),
               "entry count changed outside a finishing transaction")

endmodule

`default_nettype wire

FILE: src/ordered_key_set_table.sv
// A read goes from accept through S_LOOK, S_READ and S_READ_DONE to done_o; add,
//   find and remove scan the table through S_LOOK and S_CMP per entry compared,
//   add appends in S_APPEND and remove moves each later entry via S_MOVE_RD, S_MOVE_WR.
// Only one transaction is in flight at a time; done_o pulses one cycle as busy drops,
//   and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the table; entries need no clearing.
`default_nettype none
`include "assert_macros.svh"

module ordered_key_set_table import okst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  action_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] entry_data_i,
  input  wire logic               has_data_i,
  input  wire logic        [3:0]  position_i,
  output logic                    done_o,
  output logic             [1:0]  status_o,
  output logic             [3:0]  found_position_o,
  output logic signed      [31:0] key_out_o,
  output logic signed      [31:0] data_out_o,
  output logic             [4:0]  count_o
);

  okst_cmd_t  cmd;
  okst_stat_t stat;

  okst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  okst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (action_i),
    .key_i            (key_i),
    .entry_data_i     (entry_data_i),
    .has_data_i       (has_data_i),
    .position_i       (position_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .key_out_o        (key_out_o),
    .data_out_o       (data_out_o),
    .count_o          (count_o)
  );

  `OKST_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")

endmodule

`default_nettype wire

FILE: dv/ordered_key_set_table_checker.sv
`timescale 1ns / 1ps

module ordered_key_set_table_checker import okst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic        [1:0]  action_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] entry_data_i,
  input  logic               has_data_i,
  input  logic        [3:0]  position_i,
  input  logic               done_o,
  input  logic        [1:0]  status_o,
  input  logic        [3:0]  found_position_o,
  input  logic signed [31:0] key_out_o,
  input  logic signed [31:0] data_out_o,
  input  logic        [4:0]  count_o,
  output int                 fail_count,
  output int                 outstanding,
  output int                 n_checked,
  output int                 n_dup,
  output int                 n_full,
  output int                 n_missing
);

  typedef struct packed {
    status_e     status;
    logic [3:0]  fpos;
    logic [31:0] key;
    logic [31:0] data;
    logic [4:0]  count;
  } outcome_t;

  logic [31:0] key_mem  [CAPACITY];
  logic [31:0] data_mem [CAPACITY];
  int          n_entries;
  outcome_t    outcome_q[$];

  function automatic int slot_of(logic [31:0] k);
    for (int i = 0; i < n_entries; i++) begin
      if (key_mem[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one action to the mirrored table and returns the result it gives.
  function automatic outcome_t apply_action(action_e act, logic [31:0] k, logic [31:0] d,
                                            logic has, logic [3:0] pos);
    outcome_t o;
    int       slot;
    o = '0;
    o.status = ST_OK;
    case (act)
      ACT_ADD: begin
        slot = slot_of(k);
        if (slot >= 0) begin
          o.status = ST_DUP;
          o.fpos = 4'(slot);
        end else if (n_entries >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          key_mem[n_entries] = k;
          data_mem[n_entries] = has ? d : 32'd0;
          o.fpos = 4'(n_entries);
          n_entries++;
        end
      end
      ACT_REMOVE: begin
        slot = slot_of(k);
        if (slot >= 0) begin
          o.fpos = 4'(slot);
          for (int i = slot; i + 1 < n_entries; i++) begin
            key_mem[i] = key_mem[i + 1];
            data_mem[i] = data_mem[i + 1];
          end
          n_entries--;
        end else begin
          o.status = ST_MISSING;
        end
      end
      ACT_READ: begin
        if (int'(pos) < n_entries) begin
          o.fpos = pos;
          o.key = key_mem[pos];
          o.data = data_mem[pos];
        end else begin
          o.status = ST_MISSING;
        end
      end
      default: begin
        slot = slot_of(k);
        if (slot >= 0) o.fpos = 4'(slot);
        else o.status = ST_MISSING;
      end
    endcase
    o.count = 5'(n_entries);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t want;
    if (!rst_ni) begin
      n_entries = 0;
      outcome_q.delete();
      outstanding = 0;
    end else begin
      // result first: it belongs to an older transaction than one accepted now
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: %0t unexpected result status %0d pos %0d count %0d",
                     $realtime, status_o, found_position_o, count_o);
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          case (want.status)
            ST_DUP:     n_dup++;
            ST_FULL:    n_full++;
            ST_MISSING: n_missing++;
            default: ;
          endcase
          if (status_o !== want.status || found_position_o !== want.fpos ||
              key_out_o !== want.key || data_out_o !== want.data ||
              count_o !== want.count) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: %0t mismatch on transaction %0d", $realtime, n_checked);
              $display("  expected status %0d pos %0d key %h data %h count %0d",
                       want.status, want.fpos, want.key, want.data, want.count);
              $display("  actual   status %0d pos %0d key %h data %h count %0d",
                       status_o, found_position_o, key_out_o, data_out_o, count_o);
            end
          end
        end
      end
      if (start && !busy)
        outcome_q.push_back(apply_action(action_e'(action_i), key_i, entry_data_i,
                                         has_data_i, position_i));
      outstanding = outcome_q.size();
    end
  end

endmodule

FILE: dv/ordered_key_set_table_tb.sv
`timescale 1ns / 1ps

module ordered_key_set_table_tb;
  import okst_pkg::*;

  localparam int CAPACITY = 16;
  localparam int N_RANDOM = 1525;
  localparam int POOL_SIZE = 24;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic        [1:0]  action_i = ACT_ADD;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] entry_data_i = '0;
  logic               has_data_i = 1'b0;
  logic        [3:0]  position_i = '0;
  logic               done_o;
  logic        [1:0]  status_o;
  logic        [3:0]  found_position_o;
  logic signed [31:0] key_out_o;
  logic signed [31:0] data_out_o;
  logic        [4:0]  count_o;

  int fail_count, outstanding, n_checked, n_dup, n_full, n_missing;
  int n_sent;
  bit idle_on;
  logic [31:0] key_pool [POOL_SIZE];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ordered_key_set_table #(.CAPACITY(CAPACITY)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .key_i(key_i), .entry_data_i(entry_data_i),
    .has_data_i(has_data_i), .position_i(position_i), .done_o(done_o),
    .status_o(status_o), .found_position_o(found_position_o),
    .key_out_o(key_out_o), .data_out_o(data_out_o), .count_o(count_o)
  );

  ordered_key_set_table_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .key_i(key_i), .entry_data_i(entry_data_i),
    .has_data_i(has_data_i), .position_i(position_i), .done_o(done_o),
    .status_o(status_o), .found_position_o(found_position_o),
    .key_out_o(key_out_o), .data_out_o(data_out_o), .count_o(count_o),
    .fail_count(fail_count), .outstanding(outstanding), .n_checked(n_checked),
    .n_dup(n_dup), .n_full(n_full), .n_missing(n_missing)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(action_e act, logic [31:0] k, logic [31:0] d, logic has,
                           logic [3:0] pos);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    key_i <= k;
    entry_data_i <= d;
    has_data_i <= has;
    position_i <= pos;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int add_pct, r, guard;
    action_e act;
    logic [31:0] k;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    idle_on = 1'b1;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table
    send_item(ACT_READ, $urandom, $urandom, 1'b1, 4'd0);
    send_item(ACT_FIND, key_pool[0], $urandom, 1'b0, 4'd0);
    send_item(ACT_REMOVE, key_pool[0], $urandom, 1'b1, 4'd15);
    // extreme keys and data, with and without data
    send_item(ACT_ADD, key_pool[0], 32'h7FFF_FFFF, 1'b1, 4'd0);
    send_item(ACT_ADD, key_pool[1], 32'hFFFF_FFFF, 1'b0, 4'd0);
    send_item(ACT_ADD, key_pool[2], 32'h8000_0000, 1'b1, 4'd0);
    send_item(ACT_ADD, key_pool[1], 32'h1234_5678, 1'b1, 4'd0);
    send_item(ACT_FIND, key_pool[2], 32'd0, 1'b0, 4'd0);
    // remove at the head shifts the rest down
    send_item(ACT_REMOVE, key_pool[0], 32'd0, 1'b0, 4'd0);
    for (int i = 3; i < 17; i++) send_item(ACT_ADD, key_pool[i], $urandom, 1'b1, 4'(i));
    send_item(ACT_ADD, key_pool[17], $urandom, 1'b1, 4'd0);
    send_item(ACT_ADD, key_pool[5], $urandom, 1'b1, 4'd0);
    send_item(ACT_READ, 32'd0, 32'd0, 1'b0, 4'd15);
    send_item(ACT_FIND, key_pool[20], 32'd0, 1'b0, 4'd0);
    drain();

    add_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: add_pct = 75;
          1: add_pct = 50;
          default: add_pct = 25;
        endcase
      end
      if (n % 400 == 399) drain();
      r = $urandom_range(0, 99);
      if (r < add_pct) act = ACT_ADD;
      else if (r < add_pct + (100 - add_pct) / 2) act = ACT_REMOVE;
      else if (r[0]) act = ACT_READ;
      else act = ACT_FIND;
      // adds stay inside the pool so the table can always be drained again
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (act != ACT_ADD && $urandom_range(0, 9) == 0) k = $urandom;
      send_item(act, k, $urandom, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end
    start <= 1'b0;

    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (outstanding != 0 && guard < 5000);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (outstanding != 0)
      $display("ERROR: %0d transactions never produced a result", outstanding);

    $display("Summary: %0d transactions sent, %0d results checked", n_sent, n_checked);
    $display("  %0d duplicate adds, %0d adds to a full table, %0d not-found results",
             n_dup, n_full, n_missing);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/okst_pkg.sv
src/okst_ram.sv
src/okst_ctrl.sv
src/okst_dp.sv
src/ordered_key_set_table.sv
dv/ordered_key_set_table_checker.sv
dv/ordered_key_set_table_tb.sv
